[hdl/pat_pkg.sv]
package pat_pkg;

    // Operation codes carried in the kind field
    typedef enum logic [2:0] {
        KIND_CLEAR  = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_DELETE = 3'd2,
        KIND_SEARCH = 3'd3,
        KIND_READ   = 3'd4
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_INVALID   = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    // What every cell of the chain does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2
    } cell_op_t;

    localparam int DATA_W = 32;

endpackage

[hdl/pac_cell.sv]
module pac_cell #(
    parameter int IDXW  = 6,
    parameter int INDEX = 0
) (
    input  logic                        clk,
    input  pat_pkg::cell_op_t           op,
    input  logic [IDXW-1:0]             pos,
    input  logic [pat_pkg::DATA_W-1:0]  load_value,
    input  logic [pat_pkg::DATA_W-1:0]  left,
    input  logic [pat_pkg::DATA_W-1:0]  right,
    output logic [pat_pkg::DATA_W-1:0]  data
);

    localparam logic [IDXW-1:0] MY_INDEX = IDXW'(INDEX);

    logic [pat_pkg::DATA_W-1:0] data_reg;
    logic [pat_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            pat_pkg::CELL_HOLD:
            begin
                data_next = data_reg;
            end
            pat_pkg::CELL_INSERT:
            begin
                // cells above the slot take the left neighbor, the slot takes the new word
                if (MY_INDEX > pos)
                begin
                    data_next = left;
                end
                else if (MY_INDEX == pos)
                begin
                    data_next = load_value;
                end
            end
            pat_pkg::CELL_SHIFT:
            begin
                // cells at and above pos pull from the right neighbor
                if (MY_INDEX >= pos)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[hdl/positional_array_table.sv]
// Channel  | Direction | Handshake                  | Payload
// item     | in        | item_valid / item_ready     | kind, position, value
// result   | out       | result_valid / result_ready | status, found_index, read_value, count
//
// Clear, insert, delete, a search of an empty table and every refused operation: the
// word is accepted and its result is registered at the next edge.
// Read in range and search of a non-empty table: the chain of cells rotates once
// through cell 0, where the single comparator and read tap sit.
// A new word is taken in idle once the result register is empty or being emptied.
// rst_n clears the count, the sequencer and the result valid; table contents are not reset.
// A stalled result holds the block; no further word is accepted until it drains.
module positional_array_table #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [2:0]         kind,
    input  logic [6:0]         position,
    input  logic signed [31:0] value,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [1:0]         status,
    output logic [5:0]         found_index,
    output logic signed [31:0] read_value,
    output logic [6:0]         count
);

    localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > 7) ? CW : 7) + 1;
    localparam int DW   = pat_pkg::DATA_W;

    localparam logic [CW-1:0]   COUNT_FULL = CW'(CAPACITY);
    localparam logic [IDXW-1:0] SCAN_LAST  = IDXW'(CAPACITY - 1);

    // Sequencer: idle takes words, scan rotates the chain for read and search
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]   count_reg, count_next;
    logic [IDXW-1:0] scan_cnt_reg, scan_cnt_next;
    logic            is_search_reg, is_search_next;
    logic [IDXW-1:0] pos_reg, pos_next;
    logic [DW-1:0]   val_reg, val_next;
    logic            hit_reg, hit_next;
    logic [IDXW-1:0] hit_idx_reg, hit_idx_next;
    logic [DW-1:0]   rd_reg, rd_next;

    logic            res_valid_reg, res_valid_next;
    logic [1:0]      res_status_reg, res_status_next;
    logic [IDXW-1:0] res_found_reg, res_found_next;
    logic [DW-1:0]   res_read_reg, res_read_next;

    pat_pkg::cell_op_t cell_op;
    logic [IDXW-1:0]   cell_pos;
    logic [DW-1:0]     cell_data [CAPACITY];

    logic accept;
    logic ins_ok;
    logic pos_in_range;
    logic match_now;
    logic scan_in_count;

    // Take a word only when the result slot is free by the next edge
    assign item_ready = (state_reg == ST_IDLE) && (!res_valid_reg || result_ready);
    assign accept     = item_valid && item_ready;

    assign ins_ok       = (CMPW'(position) <= CMPW'(count_reg)) && (count_reg < COUNT_FULL);
    assign pos_in_range = CMPW'(position) < CMPW'(count_reg);

    // Cell 0 shows entry scan_cnt during the rotation
    assign scan_in_count = CW'(scan_cnt_reg) < count_reg;
    assign match_now     = is_search_reg && !hit_reg && scan_in_count
                           && (cell_data[0] == val_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_cnt_next  = scan_cnt_reg;
        is_search_next = is_search_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        rd_next        = rd_reg;
        cell_op        = pat_pkg::CELL_HOLD;
        cell_pos       = IDXW'(position);

        res_valid_next  = res_valid_reg && !result_ready;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_read_next   = res_read_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // default answer: refused, nothing changes
                    res_valid_next  = 1'b1;
                    res_status_next = pat_pkg::STAT_INVALID;
                    res_found_next  = '0;
                    res_read_next   = '0;
                    pos_next        = IDXW'(position);
                    val_next        = value;
                    hit_next        = 1'b0;
                    hit_idx_next    = '0;
                    rd_next         = '0;
                    scan_cnt_next   = '0;
                    unique case (kind)
                        pat_pkg::KIND_CLEAR:
                        begin
                            count_next      = '0;
                            res_status_next = pat_pkg::STAT_DONE;
                        end
                        pat_pkg::KIND_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                cell_op         = pat_pkg::CELL_INSERT;
                                count_next      = count_reg + CW'(1);
                                res_status_next = pat_pkg::STAT_DONE;
                            end
                        end
                        pat_pkg::KIND_DELETE:
                        begin
                            if (pos_in_range)
                            begin
                                cell_op         = pat_pkg::CELL_SHIFT;
                                count_next      = count_reg - CW'(1);
                                res_status_next = pat_pkg::STAT_DONE;
                            end
                        end
                        pat_pkg::KIND_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = pat_pkg::STAT_NOT_FOUND;
                            end
                            else
                            begin
                                res_valid_next = 1'b0;
                                is_search_next = 1'b1;
                                state_next     = ST_SCAN;
                            end
                        end
                        pat_pkg::KIND_READ:
                        begin
                            if (pos_in_range)
                            begin
                                res_valid_next = 1'b0;
                                is_search_next = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            res_status_next = pat_pkg::STAT_INVALID;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // rotate the whole chain one place toward cell 0
                cell_op       = pat_pkg::CELL_SHIFT;
                cell_pos      = '0;
                scan_cnt_next = scan_cnt_reg + IDXW'(1);
                if (match_now)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = scan_cnt_reg;
                end
                if (!is_search_reg && (scan_cnt_reg == pos_reg))
                begin
                    rd_next = cell_data[0];
                end
                if (scan_cnt_reg == SCAN_LAST)
                begin
                    // chain is back in order after the last shift: post the result
                    state_next     = ST_IDLE;
                    res_valid_next = 1'b1;
                    if (is_search_reg)
                    begin
                        res_read_next = '0;
                        if (hit_reg || match_now)
                        begin
                            res_status_next = pat_pkg::STAT_DONE;
                            res_found_next  = hit_reg ? hit_idx_reg : scan_cnt_reg;
                        end
                        else
                        begin
                            res_status_next = pat_pkg::STAT_NOT_FOUND;
                            res_found_next  = '0;
                        end
                    end
                    else
                    begin
                        res_status_next = pat_pkg::STAT_DONE;
                        res_found_next  = '0;
                        res_read_next   = (scan_cnt_reg == pos_reg) ? cell_data[0] : rd_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_cnt_reg  <= scan_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Operands and result payload
    always_ff @(posedge clk)
    begin
        is_search_reg  <= is_search_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        rd_reg         <= rd_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_read_reg   <= res_read_next;
    end

    // Chain of cells: cell i holds entry i; the last cell wraps to cell 0 on a shift
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int LEFT  = (i == 0) ? 0 : i - 1;
        localparam int RIGHT = (i + 1) % CAPACITY;

        pac_cell #(
            .IDXW  (IDXW),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .pos        (cell_pos),
            .load_value (val_next),
            .left       (cell_data[LEFT]),
            .right      (cell_data[RIGHT]),
            .data       (cell_data[i])
        );
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign found_index  = 6'(res_found_reg);
    assign read_value   = res_read_reg;
    assign count        = 7'(count_reg);

    // Count never runs past the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("entry count above capacity");

    // The result slot is empty for the whole rotation
    a_scan_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !res_valid_reg)
        else $error("result pending during scan");

    // A clear posts a done result with an empty table
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == pat_pkg::KIND_CLEAR)) |=>
        (res_valid_reg && (count_reg == '0) && (res_status_reg == pat_pkg::STAT_DONE)))
        else $error("clear did not empty the table");

    // Insert into a full table is refused and leaves the count alone
    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == pat_pkg::KIND_INSERT) && (count_reg == COUNT_FULL)) |=>
        ((res_status_reg == pat_pkg::STAT_INVALID) && (count_reg == COUNT_FULL)))
        else $error("insert into full table not refused");

endmodule
